FILE: sv/mqsb_pkg.sv
// Shared types, constants and helpers for the multi-queue shared buffer.
`default_nettype none

package mqsb_pkg;

    // Default sizes of the buffer
    localparam int unsigned SLOTS_DEF      = 1024;
    localparam int unsigned QUEUES_DEF     = 8;
    localparam int unsigned DATA_WIDTH_DEF = 32;

    // Fixed field widths of the request and result
    localparam int unsigned QNUM_W  = 3;
    localparam int unsigned VALUE_W = 32;

    // Request actions
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    typedef struct packed {
        logic                      action;
        logic [QNUM_W-1:0]         queue_number;
        logic signed [VALUE_W-1:0] push_value;
    } request_t;

    typedef struct packed {
        logic                      success;
        logic signed [VALUE_W-1:0] pop_value;
    } result_t;

    // Address width of a store with n entries, at least one bit
    function automatic int unsigned addr_width(input int unsigned n);
        int unsigned w;
        w = (n > 1) ? $clog2(n) : 1;
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: sv/mqsb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mqsb_ram #(
    parameter int unsigned WIDTH = mqsb_pkg::DATA_WIDTH_DEF,
    parameter int unsigned DEPTH = mqsb_pkg::SLOTS_DEF
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [mqsb_pkg::addr_width(DEPTH)-1:0]    waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [mqsb_pkg::addr_width(DEPTH)-1:0]    raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/multi_queue_shared_buffer.sv
// Top level: several FIFO queues kept as linked lists in one shared slot store.
//
//  channel   signals                    transfer
//  -------   ------------------------   -----------------------------------------
//  request   start, busy, request       edge with start high and busy low
//  result    done, result               edge ending the single cycle done is high
//
//  A push, a pop from an empty queue and a request to a missing queue pass
//  through S_PTR to the result strobe, busy high there; a pop that removes a
//  value passes through S_PTR and S_POP, busy high in both. That pop reads the
//  queue pointer RAM, then the link and data RAMs at the head slot, then writes
//  back. Reset empties every queue through per-queue valid bits and a high-water
//  mark for untouched slots, so no clearing pass runs. The receiver cannot stall.
`default_nettype none

module multi_queue_shared_buffer #(
    parameter int unsigned SLOTS      = mqsb_pkg::SLOTS_DEF,
    parameter int unsigned QUEUES     = mqsb_pkg::QUEUES_DEF,
    parameter int unsigned DATA_WIDTH = mqsb_pkg::DATA_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire mqsb_pkg::request_t request,
    output logic                    done,
    output mqsb_pkg::result_t       result
);

    localparam int unsigned AW  = mqsb_pkg::addr_width(SLOTS);
    localparam int unsigned LW  = $clog2(SLOTS + 1);
    localparam int unsigned QAW = mqsb_pkg::addr_width(QUEUES);
    localparam int unsigned QXW = (QAW > mqsb_pkg::QNUM_W) ? QAW : mqsb_pkg::QNUM_W;
    localparam int unsigned VW  = mqsb_pkg::VALUE_W;

    localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PTR  = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    // Control and pointer registers
    logic [1:0]       state_reg,     state_next;
    logic [LW-1:0]    free_head_reg, free_head_next;
    logic [LW-1:0]    hwm_reg,       hwm_next;
    logic [QUEUES-1:0] qvalid_reg,   qvalid_next;
    logic             done_reg,      done_next;

    // Payload registers
    logic             act_reg,   act_next;
    logic [QXW-1:0]   q_reg,     q_next;
    logic [VW-1:0]    value_reg, value_next;
    logic [LW-1:0]    head_reg,  head_next;
    logic [LW-1:0]    tail_reg,  tail_next;
    mqsb_pkg::result_t result_reg, result_next;

    // RAM ports
    logic             link_we;
    logic [AW-1:0]    link_waddr, link_raddr;
    logic [LW-1:0]    link_wdata, link_rdata;
    logic             data_we;
    logic [AW-1:0]    data_waddr, data_raddr;
    logic [DATA_WIDTH-1:0] data_wdata, data_rdata;
    logic             qp_we;
    logic [QAW-1:0]   qp_raddr;
    logic [2*LW-1:0]  qp_wdata, qp_rdata;

    // Decoded working values
    logic [QXW-1:0]   q_in_wide;
    logic [QAW-1:0]   q_addr;
    logic             q_ok;
    logic             q_live;
    logic [LW-1:0]    cur_head, cur_tail;
    logic [LW-1:0]    slot_inc;
    logic [63:0]      value_wide;
    logic [63:0]      rdata_wide;

    mqsb_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    mqsb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SLOTS)) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (data_waddr),
        .wdata (data_wdata),
        .raddr (data_raddr),
        .rdata (data_rdata)
    );

    mqsb_ram #(.WIDTH(2 * LW), .DEPTH(QUEUES)) u_qptr_ram (
        .clk   (clk),
        .we    (qp_we),
        .waddr (q_addr),
        .wdata (qp_wdata),
        .raddr (qp_raddr),
        .rdata (qp_rdata)
    );

    // Decode the addressed queue and its pointers
    always_comb
    begin
        q_in_wide  = QXW'(request.queue_number);
        q_addr     = q_reg[QAW-1:0];
        q_ok       = ({1'b0, q_reg} < (QXW + 1)'(QUEUES));
        q_live     = q_ok && qvalid_reg[q_addr];
        cur_head   = q_live ? qp_rdata[2*LW-1:LW] : NULL_LINK;
        cur_tail   = q_live ? qp_rdata[LW-1:0]    : NULL_LINK;
        slot_inc   = free_head_reg + LW'(1);
        value_wide = {32'b0, value_reg};
        rdata_wide = 64'($signed(data_rdata));
    end

    // Sequence one request through the pointer, link and data RAMs
    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        hwm_next       = hwm_reg;
        qvalid_next    = qvalid_reg;
        done_next      = 1'b0;
        act_next       = act_reg;
        q_next         = q_reg;
        value_next     = value_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        result_next    = '0;

        link_we    = 1'b0;
        link_waddr = tail_reg[AW-1:0];
        link_wdata = free_head_reg;
        link_raddr = free_head_reg[AW-1:0];
        data_we    = 1'b0;
        data_waddr = free_head_reg[AW-1:0];
        data_wdata = value_wide[DATA_WIDTH-1:0];
        data_raddr = cur_head[AW-1:0];
        qp_we      = 1'b0;
        qp_wdata   = {cur_head, free_head_reg};
        qp_raddr   = q_in_wide[QAW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                // Accept a request; fetch its queue pointers and the free link
                if (start)
                begin
                    act_next   = request.action;
                    q_next     = q_in_wide;
                    value_next = request.push_value;
                    state_next = S_PTR;
                end
            end

            S_PTR:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (!q_ok)
                begin
                    // Drop a request to a queue that does not exist
                    result_next = '0;
                end
                else if (act_reg == mqsb_pkg::ACT_PUSH)
                begin
                    if (free_head_reg != NULL_LINK)
                    begin
                        // Take the free head slot; untouched slots link to the next one
                        free_head_next = (free_head_reg >= hwm_reg) ? slot_inc : link_rdata;
                        if (free_head_reg == hwm_reg)
                        begin
                            hwm_next = slot_inc;
                        end
                        data_we = 1'b1;
                        // Link the slot after the tail, or start the queue with it
                        if (cur_head == NULL_LINK)
                        begin
                            qp_wdata = {free_head_reg, free_head_reg};
                        end
                        else
                        begin
                            link_we    = 1'b1;
                            link_waddr = cur_tail[AW-1:0];
                            link_wdata = free_head_reg;
                            qp_wdata   = {cur_head, free_head_reg};
                        end
                        qp_we               = 1'b1;
                        qvalid_next[q_addr] = 1'b1;
                        result_next.success = 1'b1;
                    end
                end
                else
                begin
                    if (cur_head != NULL_LINK)
                    begin
                        // Fetch the head slot's link and data
                        head_next  = cur_head;
                        tail_next  = cur_tail;
                        link_raddr = cur_head[AW-1:0];
                        state_next = S_POP;
                        done_next  = 1'b0;
                    end
                end
            end

            S_POP:
            begin
                // Unlink the head, return it to the front of the free list
                qp_we = 1'b1;
                if (head_reg == tail_reg)
                begin
                    qp_wdata = {NULL_LINK, NULL_LINK};
                end
                else
                begin
                    qp_wdata = {link_rdata, tail_reg};
                end
                link_we               = 1'b1;
                link_waddr            = head_reg[AW-1:0];
                link_wdata            = free_head_reg;
                free_head_next        = head_reg;
                result_next.success   = 1'b1;
                result_next.pop_value = rdata_wide[VW-1:0];
                done_next             = 1'b1;
                state_next            = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            hwm_reg       <= '0;
            qvalid_reg    <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            hwm_reg       <= hwm_next;
            qvalid_reg    <= qvalid_next;
            done_reg      <= done_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        q_reg      <= q_next;
        value_reg  <= value_next;
        head_reg   <= head_next;
        tail_reg   <= tail_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the multi-queue shared buffer with an internal linked-list predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS       = mqsb_pkg::SLOTS_DEF;
    localparam int unsigned QUEUES      = mqsb_pkg::QUEUES_DEF;
    localparam int unsigned DATA_WIDTH  = mqsb_pkg::DATA_WIDTH_DEF;
    localparam int unsigned LINK_W      = $clog2(SLOTS + 1);
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned MIXED_ITEMS = 120;
    localparam int unsigned TAIL_ITEMS  = 120;
    localparam int unsigned FULL_PUSHES = 12;

    typedef logic [LINK_W-1:0] link_t;
    localparam link_t LINK_NULL = link_t'(SLOTS);

    // Linked-list image of the slot store plus the queue of expected results
    class shared_queue_checker;
        logic [DATA_WIDTH-1:0] slot_data [SLOTS];
        link_t                 slot_link [SLOTS];
        link_t                 queue_head [QUEUES];
        link_t                 queue_tail [QUEUES];
        link_t                 free_head;
        int unsigned           used_slots;
        int unsigned           queue_fill [QUEUES];
        mqsb_pkg::result_t     expected_results [$];
        int unsigned           errors;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_data[i] = '0;
                slot_link[i] = link_t'(i + 1);
            end
            slot_link[SLOTS-1] = LINK_NULL;
            for (int i = 0; i < QUEUES; i++)
            begin
                queue_head[i] = LINK_NULL;
                queue_tail[i] = LINK_NULL;
                queue_fill[i] = 0;
            end
            free_head  = '0;
            used_slots = 0;
            errors     = 0;
        endfunction

        // Apply one accepted request and queue the result it must produce
        function void note_request(mqsb_pkg::request_t req);
            mqsb_pkg::result_t res;
            link_t             slot;
            int unsigned       q;
            res = '0;
            q   = req.queue_number;
            if (q < QUEUES)
            begin
                if (req.action == mqsb_pkg::ACT_PUSH)
                begin
                    // take the free-list head and link it after the tail
                    if (free_head != LINK_NULL)
                    begin
                        slot            = free_head;
                        free_head       = slot_link[slot];
                        slot_data[slot] = DATA_WIDTH'($unsigned(req.push_value));
                        if (queue_head[q] == LINK_NULL || queue_tail[q] == LINK_NULL)
                            queue_head[q] = slot;
                        else
                            slot_link[queue_tail[q]] = slot;
                        slot_link[slot] = LINK_NULL;
                        queue_tail[q]   = slot;
                        used_slots++;
                        queue_fill[q]++;
                        res.success = 1'b1;
                    end
                end
                else
                begin
                    // unlink the head slot and return it to the free list
                    if (queue_head[q] != LINK_NULL)
                    begin
                        slot          = queue_head[q];
                        queue_head[q] = slot_link[slot];
                        if (queue_head[q] == LINK_NULL)
                            queue_tail[q] = LINK_NULL;
                        slot_link[slot] = free_head;
                        free_head       = slot;
                        used_slots--;
                        queue_fill[q]--;
                        res.success   = 1'b1;
                        res.pop_value = $signed(slot_data[slot]);
                    end
                end
            end
            expected_results = {expected_results, res};
        endfunction

        // Compare one strobed result against the oldest expectation
        function void check_result(mqsb_pkg::result_t got);
            mqsb_pkg::result_t exp_res;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual success=%0b pop_value=%0d",
                         $time, got.success, got.pop_value);
                errors++;
            end
            else
            begin
                exp_res = expected_results[0];
                expected_results.delete(0);
                if (got.success !== exp_res.success)
                begin
                    $display("%0t: success mismatch: expected %0b, actual %0b",
                             $time, exp_res.success, got.success);
                    errors++;
                end
                if (got.pop_value !== exp_res.pop_value)
                begin
                    $display("%0t: pop_value mismatch: expected %0d, actual %0d",
                             $time, exp_res.pop_value, got.pop_value);
                    errors++;
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               done;
    mqsb_pkg::request_t request;
    mqsb_pkg::result_t  result;

    shared_queue_checker queue_model = new();
    int unsigned         cycle_count = 0;

    multi_queue_shared_buffer uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Check every strobed result
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            queue_model.check_result(result);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Pick a value that often lands on a field extreme
    function automatic logic signed [mqsb_pkg::VALUE_W-1:0] pick_value();
        unique case ($urandom_range(7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Pick a queue, a non-empty one when asked and the store holds data
    function automatic logic [mqsb_pkg::QNUM_W-1:0] pick_queue(input bit want_data);
        int unsigned q;
        q = $urandom_range(QUEUES - 1);
        if (want_data && queue_model.used_slots > 0)
        begin
            while (queue_model.queue_fill[q] == 0)
                q = $urandom_range(QUEUES - 1);
        end
        return mqsb_pkg::QNUM_W'(q);
    endfunction

    // Present one request and hold it until the transfer
    task automatic send_request(input logic act, input logic [mqsb_pkg::QNUM_W-1:0] qn,
                                input logic signed [mqsb_pkg::VALUE_W-1:0] val);
        mqsb_pkg::request_t req;
        req.action       = act;
        req.queue_number = qn;
        req.push_value   = val;
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        queue_model.note_request(req);
    endtask

    // Drop start for a number of cycles
    task automatic hold_idle(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop start until every expected result has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (queue_model.expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Send a random request, push with the given percentage, maybe idle after
    task automatic send_random(input int unsigned push_pct, input bit allow_idle);
        logic act;
        act = ($urandom_range(99) < push_pct) ? mqsb_pkg::ACT_PUSH : mqsb_pkg::ACT_POP;
        send_request(act, pick_queue(act == mqsb_pkg::ACT_POP && $urandom_range(9) < 8),
                     pick_value());
        if (allow_idle && $urandom_range(9) == 0)
            hold_idle($urandom_range(1, 18));
    endtask

    initial
    begin
        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, empty pops, queue emptied and refilled
        send_request(mqsb_pkg::ACT_PUSH, 3'd0, 32'sh7FFF_FFFF);
        send_request(mqsb_pkg::ACT_PUSH, 3'd7, 32'sh8000_0000);
        send_request(mqsb_pkg::ACT_PUSH, 3'd3, 32'sh0000_0000);
        send_request(mqsb_pkg::ACT_PUSH, 3'd0, 32'shFFFF_FFFF);
        send_request(mqsb_pkg::ACT_PUSH, 3'd5, 32'sh5555_5555);
        send_request(mqsb_pkg::ACT_PUSH, 3'd2, 32'shAAAA_AAAA);
        send_request(mqsb_pkg::ACT_POP,  3'd1, 32'sh5A5A_A5A5);
        send_request(mqsb_pkg::ACT_POP,  3'd0, 32'shFFFF_FFFF);
        send_request(mqsb_pkg::ACT_POP,  3'd0, 32'sh0000_0000);
        send_request(mqsb_pkg::ACT_POP,  3'd0, 32'sh1234_5678);
        send_request(mqsb_pkg::ACT_PUSH, 3'd0, 32'sh1234_5678);
        send_request(mqsb_pkg::ACT_POP,  3'd0, 32'sh0000_0000);
        send_request(mqsb_pkg::ACT_POP,  3'd7, 32'sh0000_0000);
        send_request(mqsb_pkg::ACT_POP,  3'd3, 32'sh0000_0000);
        send_request(mqsb_pkg::ACT_POP,  3'd5, 32'sh0000_0000);
        send_request(mqsb_pkg::ACT_POP,  3'd2, 32'sh0000_0000);
        send_request(mqsb_pkg::ACT_POP,  3'd4, 32'sh0000_0000);
        send_request(mqsb_pkg::ACT_POP,  3'd6, 32'sh0000_0000);
        send_request(mqsb_pkg::ACT_PUSH, 3'd6, 32'shFFFF_FFFF);
        send_request(mqsb_pkg::ACT_PUSH, 3'd4, 32'sh8000_0000);
        send_request(mqsb_pkg::ACT_POP,  3'd6, 32'sh0000_0000);
        send_request(mqsb_pkg::ACT_POP,  3'd4, 32'sh0000_0000);
        wait_drained();

        // Mixed traffic over all queues
        repeat (MIXED_ITEMS) send_random(55, 1'b1);

        // Fill the store, then push against a full store
        while (queue_model.used_slots < SLOTS)
            send_random(96, 1'b1);
        repeat (FULL_PUSHES) send_request(mqsb_pkg::ACT_PUSH, pick_queue(1'b0), pick_value());
        send_request(mqsb_pkg::ACT_POP, pick_queue(1'b1), pick_value());
        send_request(mqsb_pkg::ACT_PUSH, pick_queue(1'b0), pick_value());
        send_request(mqsb_pkg::ACT_PUSH, pick_queue(1'b0), pick_value());
        wait_drained();

        // Drain-heavy tail without idling
        repeat (TAIL_ITEMS) send_random(30, 1'b0);

        // Wait out the last results
        wait_drained();
        repeat (8) @(posedge clk);
        if (queue_model.expected_results.size() != 0)
        begin
            $display("%0t: results missing: expected %0d more, actual 0",
                     $time, queue_model.expected_results.size());
            queue_model.errors++;
        end
        if (queue_model.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
sv/mqsb_pkg.sv
sv/mqsb_ram.sv
sv/multi_queue_shared_buffer.sv
tb/tb.sv
